### hdl/ssmf_pkg.sv
// Shared constants and types for the stereo state variable filter with output morph.
// Used by ssmf_mul, ssmf_core and stereo_svf_morph_filter; depends on nothing.
package ssmf_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int STATE_BITS_DEF  = 40;

  localparam int COEF_FRAC  = 24;
  localparam int BLEND_FRAC = 8;
  localparam int COEF_W     = 33;
  localparam int COEF_CHUNK = 17;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MORPH_W    = 10;
  localparam int A1_W       = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_G      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MORPH  = 3'd4;

  localparam logic               ENABLE_RST = 1'b1;
  localparam logic [31:0]        G_RST      = 32'd1099000;
  localparam logic [31:0]        K_RST      = 32'd23726566;
  localparam logic [A1_W-1:0]    A1_RST     = 25'd15295000;
  localparam logic [MORPH_W-1:0] MORPH_RST  = 10'd0;

  // Morph zone limits in Q2.8: 0.5, 1.5, 2.0, 3.0 and 3.5.
  localparam logic [MORPH_W-1:0] MORPH_LP = 10'd128;
  localparam logic [MORPH_W-1:0] MORPH_LB = 10'd384;
  localparam logic [MORPH_W-1:0] MORPH_BP = 10'd512;
  localparam logic [MORPH_W-1:0] MORPH_BH = 10'd768;
  localparam logic [MORPH_W-1:0] MORPH_HP = 10'd896;

  typedef struct packed {
    logic [31:0]        g;
    logic [31:0]        k;
    logic [A1_W-1:0]    a1;
    logic [MORPH_W-1:0] morph;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic blend;
  } mul_ctl_t;

endpackage

### hdl/ssmf_mul.sv
// Shared multiplier: signed operand times unsigned coefficient, one coefficient chunk per cycle.
// The product is shifted right by the coefficient or blend fraction and saturated to the state.
// Depends on ssmf_pkg.
module ssmf_mul import ssmf_pkg::*; #(
  parameter int STATE_BITS = STATE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mul_ctl_t                     ctl_i,
  input  logic signed [STATE_BITS:0]   a_i,
  input  logic        [COEF_W-1:0]     c_i,
  output logic                         done_o,
  output logic signed [STATE_BITS-1:0] prod_o
);

  localparam int OPW  = STATE_BITS + 1;
  localparam int NCH  = (COEF_W + COEF_CHUNK - 1) / COEF_CHUNK;
  localparam int IDXW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int CPW  = NCH * COEF_CHUNK;
  localparam int PPW  = OPW + COEF_CHUNK + 1;
  localparam int ACCW = OPW + CPW + 1;
  localparam logic signed [ACCW-1:0] ST_HI =
    {{(ACCW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [ACCW-1:0] ST_LO = ~ST_HI;

  logic [CPW-1:0]               c_pad;
  logic [IDXW-1:0]              idx_q, cur_idx;
  logic [COEF_CHUNK-1:0]        chunk;
  logic signed [PPW-1:0]        pp;
  logic signed [ACCW-1:0]       pp_sh, acc_q, acc_d, shifted;
  logic signed [STATE_BITS-1:0] prod_q, prod_d;
  logic                         run_q, norm_q, done_q;

  assign c_pad   = CPW'(c_i);
  assign cur_idx = ctl_i.start ? '0 : idx_q;
  assign chunk   = c_pad[cur_idx*COEF_CHUNK +: COEF_CHUNK];
  assign pp      = a_i * $signed({1'b0, chunk});
  assign pp_sh   = ACCW'(pp) <<< (COEF_CHUNK * cur_idx);
  assign acc_d   = ctl_i.start ? pp_sh : acc_q + pp_sh;

  always_comb begin
    shifted = acc_q >>> (ctl_i.blend ? BLEND_FRAC : COEF_FRAC);
    if (shifted > ST_HI) begin
      prod_d = ST_HI[STATE_BITS-1:0];
    end else if (shifted < ST_LO) begin
      prod_d = ST_LO[STATE_BITS-1:0];
    end else begin
      prod_d = shifted[STATE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      norm_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= norm_q;
      norm_q <= 1'b0;
      if (ctl_i.start) begin
        if (NCH == 1) begin
          norm_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
          idx_q <= IDXW'(1);
        end
      end else if (run_q) begin
        if (idx_q == IDXW'(NCH - 1)) begin
          run_q  <= 1'b0;
          norm_q <= 1'b1;
        end
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start || run_q) begin
      acc_q <= acc_d;
    end
    if (norm_q) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

### hdl/ssmf_core.sv
// Sequencer and datapath for both channels: integrator states, intermediate values, morph.
// Drives the shared multiplier ssmf_mul; depends on ssmf_pkg.
module ssmf_core import ssmf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS-1:0] x_left_i,
  input  logic signed [SAMPLE_BITS-1:0] x_right_i,
  input  logic                          last_i,
  input  cfg_t                          cfg_i,
  output logic                          idle_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic signed [SAMPLE_BITS-1:0] y_left_o,
  output logic signed [SAMPLE_BITS-1:0] y_right_o,
  output logic                          last_o
);

  localparam int SW  = STATE_BITS;
  localparam int XW  = SAMPLE_BITS;
  localparam int OPW = SW + 1;
  localparam int WW  = SW + 2;
  localparam logic signed [WW-1:0] W_ST_HI = WW'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [WW-1:0] W_ST_LO = ~W_ST_HI;
  localparam logic signed [WW-1:0] W_SM_HI = WW'({1'b0, {(XW-1){1'b1}}});
  localparam logic signed [WW-1:0] W_SM_LO = ~W_SM_HI;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_GK   = 4'd1;
  localparam logic [3:0] ST_A1   = 4'd2;
  localparam logic [3:0] ST_G1   = 4'd3;
  localparam logic [3:0] ST_G2   = 4'd4;
  localparam logic [3:0] ST_SEL  = 4'd5;
  localparam logic [3:0] ST_BL   = 4'd6;
  localparam logic [3:0] ST_NEXT = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  function automatic logic signed [SW-1:0] sat_st(input logic signed [WW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > W_ST_HI) begin
      r = W_ST_HI[SW-1:0];
    end else if (v < W_ST_LO) begin
      r = W_ST_LO[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [XW-1:0] clamp_smp(input logic signed [WW-1:0] v);
    logic signed [XW-1:0] r;
    if (v > W_SM_HI) begin
      r = W_SM_HI[XW-1:0];
    end else if (v < W_SM_LO) begin
      r = W_SM_LO[XW-1:0];
    end else begin
      r = v[XW-1:0];
    end
    return r;
  endfunction

  logic [3:0]               st_q, st_d;
  logic                     ch_q, ch_d;
  logic                     start_q, start_d;
  logic                     blend_q, blend_d;
  logic signed [OPW-1:0]    opa_q, opa_d;
  logic [COEF_W-1:0]        opc_q, opc_d;
  logic signed [SW-1:0]     s1_q [2];
  logic signed [SW-1:0]     s1_d [2];
  logic signed [SW-1:0]     s2_q [2];
  logic signed [SW-1:0]     s2_d [2];
  logic signed [XW-1:0]     x_q [2];
  logic signed [XW-1:0]     x_d [2];
  logic signed [XW-1:0]     y_q [2];
  logic signed [XW-1:0]     y_d [2];
  logic                     last_q, last_d;
  logic signed [SW-1:0]     hp_q, hp_d, bp_q, bp_d, gh_q, gh_d;
  logic signed [SW-1:0]     gb_q, gb_d, lp_q, lp_d, bla_q, bla_d;
  logic [COEF_W-1:0]        gk;
  logic [MORPH_W-1:0]       pos;
  logic signed [WW-1:0]     t_sum;
  logic signed [SW-1:0]     bp_new;
  logic                     mul_done;
  logic signed [SW-1:0]     prod;
  mul_ctl_t                 mul_ctl;

  assign gk     = {1'b0, cfg_i.g} + {1'b0, cfg_i.k};
  assign pos    = cfg_i.morph;
  assign t_sum  = WW'(x_q[ch_q]) - WW'(prod) - WW'(s2_q[ch_q]);
  assign bp_new = sat_st(WW'(prod) + WW'(s1_q[ch_q]));

  assign mul_ctl.start = start_q;
  assign mul_ctl.blend = blend_q;

  ssmf_mul #(
    .STATE_BITS(STATE_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .a_i    (opa_q),
    .c_i    (opc_q),
    .done_o (mul_done),
    .prod_o (prod)
  );

  always_comb begin
    st_d    = st_q;
    ch_d    = ch_q;
    start_d = 1'b0;
    blend_d = blend_q;
    opa_d   = opa_q;
    opc_d   = opc_q;
    s1_d    = s1_q;
    s2_d    = s2_q;
    x_d     = x_q;
    y_d     = y_q;
    last_d  = last_q;
    hp_d    = hp_q;
    bp_d    = bp_q;
    gh_d    = gh_q;
    gb_d    = gb_q;
    lp_d    = lp_q;
    bla_d   = bla_q;
    case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d[0]  = x_left_i;
          x_d[1]  = x_right_i;
          last_d  = last_i;
          ch_d    = 1'b0;
          opa_d   = OPW'(s1_q[0]);
          opc_d   = gk;
          blend_d = 1'b0;
          start_d = 1'b1;
          st_d    = ST_GK;
        end
      end
      ST_GK: begin
        if (mul_done) begin
          opa_d   = OPW'(sat_st(t_sum));
          opc_d   = COEF_W'(cfg_i.a1);
          start_d = 1'b1;
          st_d    = ST_A1;
        end
      end
      ST_A1: begin
        if (mul_done) begin
          hp_d    = prod;
          opa_d   = OPW'(prod);
          opc_d   = COEF_W'(cfg_i.g);
          start_d = 1'b1;
          st_d    = ST_G1;
        end
      end
      ST_G1: begin
        if (mul_done) begin
          gh_d    = prod;
          bp_d    = bp_new;
          opa_d   = OPW'(bp_new);
          opc_d   = COEF_W'(cfg_i.g);
          start_d = 1'b1;
          st_d    = ST_G2;
        end
      end
      ST_G2: begin
        if (mul_done) begin
          gb_d       = prod;
          lp_d       = sat_st(WW'(prod) + WW'(s2_q[ch_q]));
          s1_d[ch_q] = sat_st(WW'(gh_q) + WW'(bp_q));
          st_d       = ST_SEL;
        end
      end
      ST_SEL: begin
        s2_d[ch_q] = sat_st(WW'(gb_q) + WW'(lp_q));
        st_d       = ST_NEXT;
        if (pos <= MORPH_LP) begin
          y_d[ch_q] = clamp_smp(WW'(lp_q));
        end else if (pos <= MORPH_LB) begin
          bla_d   = lp_q;
          opa_d   = OPW'(bp_q) - OPW'(lp_q);
          opc_d   = COEF_W'(pos - MORPH_LP);
          blend_d = 1'b1;
          start_d = 1'b1;
          st_d    = ST_BL;
        end else if (pos <= MORPH_BP) begin
          y_d[ch_q] = clamp_smp(WW'(bp_q));
        end else if (pos <= MORPH_BH) begin
          bla_d   = bp_q;
          opa_d   = OPW'(hp_q) - OPW'(bp_q);
          opc_d   = COEF_W'(pos - MORPH_BP);
          blend_d = 1'b1;
          start_d = 1'b1;
          st_d    = ST_BL;
        end else if (pos <= MORPH_HP) begin
          y_d[ch_q] = clamp_smp(WW'(hp_q));
        end else begin
          y_d[ch_q] = '0;
        end
      end
      ST_BL: begin
        if (mul_done) begin
          y_d[ch_q] = clamp_smp(WW'(bla_q) + WW'(prod));
          st_d      = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (!ch_q) begin
          ch_d    = 1'b1;
          opa_d   = OPW'(s1_q[1]);
          opc_d   = gk;
          blend_d = 1'b0;
          start_d = 1'b1;
          st_d    = ST_GK;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      ch_q    <= 1'b0;
      start_q <= 1'b0;
      blend_q <= 1'b0;
      s1_q[0] <= '0;
      s1_q[1] <= '0;
      s2_q[0] <= '0;
      s2_q[1] <= '0;
    end else begin
      st_q    <= st_d;
      ch_q    <= ch_d;
      start_q <= start_d;
      blend_q <= blend_d;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q  <= opa_d;
    opc_q  <= opc_d;
    x_q    <= x_d;
    y_q    <= y_d;
    last_q <= last_d;
    hp_q   <= hp_d;
    bp_q   <= bp_d;
    gh_q   <= gh_d;
    gb_q   <= gb_d;
    lp_q   <= lp_d;
    bla_q  <= bla_d;
  end

  assign idle_o      = (st_q == ST_IDLE);
  assign res_valid_o = (st_q == ST_DONE);
  assign y_left_o    = y_q[0];
  assign y_right_o   = y_q[1];
  assign last_o      = last_q;

endmodule

### hdl/stereo_svf_morph_filter.sv
// Top level of the stereo state variable filter with output morph.
// Holds the configuration registers and the output register; instantiates ssmf_core.
// Depends on ssmf_pkg, ssmf_core and ssmf_mul.
//
// Usage: each slave word carries one left and one right sample and a tlast flag. The
// master side returns one filtered pair per word while enable is set, and nothing
// while it is clear. Configuration writes go through the cfg channel, which is always
// ready. The user must write only while the block is idle; the block does not check.
// Sequencing: a word is worked through four products per channel on one
// shared multiplier, plus a fifth in the two blend zones of the morph. No new word
// is accepted until the sequencer is done with the last one, and s_axis_tready
// returns in the same cycle as the result appears on the master side.
// A word accepted with enable clear is dropped and leaves s_axis_tready high.
// The output register lets the next word be accepted while a result waits; if the
// receiver stalls longer, the sequencer holds its finished result until the register
// frees up. Reset clears the integrators, loads the default coefficients and leaves
// the master side empty.
module stereo_svf_morph_filter import ssmf_pkg::*; #(
  parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter  int STATE_BITS  = STATE_BITS_DEF,
  localparam int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // left_in, right_in
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // left_out, right_out
  output logic                  m_axis_tlast
);

  logic                          enable_q;
  cfg_t                          cfg_q;
  logic                          s_accept, core_idle, res_valid, res_ready;
  logic signed [SAMPLE_BITS-1:0] y_left, y_right;
  logic                          y_last;
  logic                          m_valid_q;
  logic [SAMPLE_BITS-1:0]        m_left_q, m_right_q;
  logic                          m_last_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = core_idle;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign res_ready     = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= ENABLE_RST;
      cfg_q.g     <= G_RST;
      cfg_q.k     <= K_RST;
      cfg_q.a1    <= A1_RST;
      cfg_q.morph <= MORPH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ENABLE: enable_q    <= cfg_data_i[0];
        CFG_G:      cfg_q.g     <= cfg_data_i;
        CFG_K:      cfg_q.k     <= cfg_data_i;
        CFG_A1:     cfg_q.a1    <= cfg_data_i[A1_W-1:0];
        CFG_MORPH:  cfg_q.morph <= cfg_data_i[MORPH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssmf_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .STATE_BITS (STATE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_accept && enable_q),
    .x_left_i    ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .x_right_i   ($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .last_i      (s_axis_tlast),
    .cfg_i       (cfg_q),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .y_left_o    (y_left),
    .y_right_o   (y_right),
    .last_o      (y_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_left_q  <= y_left;
      m_right_q <= y_right;
      m_last_q  <= y_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDATA_W'({m_right_q, m_left_q});
  assign m_axis_tlast  = m_last_q;

  // A word taken while disabled must leave the block ready again at once.
  a_disabled_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && !enable_q |=> s_axis_tready)
    else $error("block stalled after a word taken while disabled");

  // A word taken while enabled must occupy the sequencer.
  a_enabled_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && enable_q |=> !s_axis_tready)
    else $error("block ready right after taking an enabled word");

  // A new result only appears after the sequencer offered one.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(res_valid))
    else $error("output valid rose without a finished result");

endmodule
